@@ hw/rtl/pltip_pkg.sv @@
// ----------------------------------------------------------------------------
// pltip_pkg: shared types and codes of the track interpolator
// Opcodes, status codes and sequencer states.
// ----------------------------------------------------------------------------
package pltip_pkg;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_QUERY  = 2'd2,
        OP_NONE   = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RSVD  = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD0,
        S_CHK0,
        S_RDL,
        S_CHKL,
        S_SCAN,
        S_SCANW,
        S_RDP,
        S_DIV,
        S_MUL,
        S_MULW,
        S_PICK,
        S_PICKW,
        S_OUT
    } state_t;

endpackage

@@ hw/rtl/piecewise_linear_track_interp_unit.sv @@
// ----------------------------------------------------------------------------
// piecewise_linear_track_interp_unit: timed 3D sample table with interpolation
// Stores samples, answers position queries by linear interpolation.
// ----------------------------------------------------------------------------
// Usage. Requests arrive on the s_ channel: tdata carries, from the lowest bit
// up, opcode[1:0], sample_time[33:2], pos_x[65:34], pos_y[97:66],
// pos_z[129:98], padded with zeros to 136 bits. Every request yields exactly
// one result on the m_ channel: tdata carries out_x[31:0], out_y[63:32],
// out_z[95:64] and status[97:96], padded to 104 bits.
// Clear, append, an unused opcode and a query on an empty table are answered
// at once: the result is offered the cycle after acceptance. A query answered
// by the first sample reads entry 0 only, and one answered by the last sample
// reads entry 0 and then the last entry. An interpolating query walks the
// table entry by entry through a single read port of the sample memories,
// then a serial divider produces alpha one quotient bit per cycle (one set-up
// step and 17 steps), and one shared multiplier interpolates the three axes.
// One request is in flight at a time; s_tready is low while it is worked on
// and while its result waits. If the receiver stalls, the result holds in
// the output register until m_tready is seen high.
// Reset (aresetn low, synchronous) empties the table and forgets the base
// time; the sample memories themselves are not cleared, since only entries
// below the fill count are ever read.
// ----------------------------------------------------------------------------
module piecewise_linear_track_interp_unit #(
    parameter int TABLE_DEPTH = 256
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // opcode, sample_time, pos_x, pos_y, pos_z (lowest first), zero padded
    input  logic [135:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // out_x, out_y, out_z, status (lowest first), zero padded
    output logic [103:0] m_tdata
);
    import pltip_pkg::*;

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    // Sample memories: one write port, one registered read port.
    logic [31:0] mem_t [TABLE_DEPTH];
    logic [31:0] mem_x [TABLE_DEPTH];
    logic [31:0] mem_y [TABLE_DEPTH];
    logic [31:0] mem_z [TABLE_DEPTH];
    logic [AW-1:0] rd_addr;
    logic [31:0] rd_t, rd_x, rd_y, rd_z;
    logic        wr_en;
    logic [AW-1:0] wr_addr;
    logic [31:0] wr_t;

    state_t state_reg, state_next;
    logic [CW-1:0] count_reg;
    logic [31:0] base_reg;
    logic        base_known_reg;
    logic [31:0] q_reg, x_in_reg, y_in_reg, z_in_reg;
    logic [CW-1:0] idx_reg;
    logic [31:0] tp_reg, tn_reg;
    logic [31:0] xn_reg, yn_reg, zn_reg;
    logic [1:0]  axis_reg;
    logic signed [31:0] pa_reg, pb_reg;
    logic [4:0]  dstep_reg;
    logic [48:0] rem_reg;
    logic [16:0] quo_reg;
    logic [32:0] gap_reg;
    logic [31:0] res_x_reg, res_y_reg, res_z_reg;
    logic [1:0]  status_reg;
    logic signed [49:0] prod_reg;

    logic accept_in, accept_out;
    assign accept_in  = s_tvalid && s_tready;
    assign accept_out = m_tvalid && m_tready;
    assign s_tready   = (state_reg == S_IDLE);
    assign m_tvalid   = (state_reg == S_OUT);
    assign m_tdata    = {6'd0, status_reg, res_z_reg, res_y_reg, res_x_reg};

    logic [31:0] s_time;
    assign s_time = s_tdata[33:2];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_t[wr_addr] <= wr_t;
            mem_x[wr_addr] <= s_tdata[65:34];
            mem_y[wr_addr] <= s_tdata[97:66];
            mem_z[wr_addr] <= s_tdata[129:98];
        end
        rd_t <= mem_t[rd_addr];
        rd_x <= mem_x[rd_addr];
        rd_y <= mem_y[rd_addr];
        rd_z <= mem_z[rd_addr];
    end

    // Appends are written straight from the request bus in the accept cycle.
    logic [31:0] eff_base;
    always_comb begin
        eff_base = base_known_reg ? base_reg : s_time;
        wr_en    = accept_in && (s_tdata[1:0] == OP_APPEND) &&
                   (count_reg < CW'(TABLE_DEPTH));
        wr_addr  = count_reg[AW-1:0];
        wr_t     = (s_time >= eff_base) ? (s_time - eff_base) : 32'd0;
    end

    logic [CW-1:0] last_idx;
    assign last_idx = count_reg - CW'(1);

    // Read address for the cycle that follows.
    always_comb begin
        case (state_next)
            S_RD0:   rd_addr = '0;
            S_RDL:   rd_addr = last_idx[AW-1:0];
            S_SCAN:  rd_addr = idx_reg[AW-1:0];
            S_RDP:   rd_addr = AW'(idx_reg - CW'(1));
            S_PICK:  rd_addr = idx_reg[AW-1:0];
            default: rd_addr = idx_reg[AW-1:0];
        endcase
    end

    // One remainder step of the restoring divider.
    logic [49:0] rem_sh;
    logic [49:0] rem_sub;
    assign rem_sh  = {rem_reg, quo_reg[16]};
    assign rem_sub = rem_sh - {17'd0, gap_reg};

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (accept_in) begin
                    if (s_tdata[1:0] == OP_QUERY && count_reg != '0) begin
                        state_next = S_RD0;
                    end else begin
                        state_next = S_OUT;
                    end
                end
            end
            S_RD0:  state_next = S_CHK0;
            S_CHK0: state_next = (q_reg <= rd_t) ? S_PICKW : S_RDL;
            S_RDL:  state_next = S_CHKL;
            S_CHKL: state_next = (q_reg < rd_t) ? S_SCANW : S_PICKW;
            S_SCANW: state_next = S_SCAN;
            S_SCAN: begin
                if (q_reg <= rd_t) begin
                    state_next = S_RDP;
                end else if (idx_reg == last_idx) begin
                    state_next = S_PICKW;
                end else begin
                    state_next = S_SCANW;
                end
            end
            S_RDP:  state_next = S_DIV;
            S_DIV:  state_next = (dstep_reg == 5'd17) ? S_MUL : S_DIV;
            S_MUL:  state_next = S_MULW;
            S_MULW: state_next = (axis_reg == 2'd2) ? S_OUT : S_MUL;
            S_PICKW: state_next = S_PICK;
            S_PICK: state_next = S_OUT;
            S_OUT:  state_next = accept_out ? S_IDLE : S_OUT;
            default: state_next = S_IDLE;
        endcase
    end

    logic [31:0] numer;
    logic [16:0] alpha;
    logic signed [32:0] diff;
    logic signed [49:0] step;
    always_comb begin
        numer = 32'd0;
        if (q_reg > tp_reg) begin
            numer = q_reg - tp_reg;
        end
        alpha = (quo_reg > 17'd65536) ? 17'd65536 : quo_reg;
        diff  = 33'(pb_reg) - 33'(pa_reg);
        step  = prod_reg >>> 16;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            base_reg       <= '0;
            base_known_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (accept_in) begin
                if (s_tdata[1:0] == OP_CLEAR) begin
                    count_reg      <= '0;
                    base_known_reg <= 1'b0;
                    base_reg       <= '0;
                end else if (wr_en) begin
                    count_reg      <= count_reg + CW'(1);
                    base_reg       <= eff_base;
                    base_known_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        case (state_reg)
            S_IDLE: begin
                q_reg      <= s_time;
                res_x_reg  <= '0;
                res_y_reg  <= '0;
                res_z_reg  <= '0;
                idx_reg    <= '0;
                status_reg <= ST_OK;
                if (s_tdata[1:0] == OP_APPEND && count_reg >= CW'(TABLE_DEPTH)) begin
                    status_reg <= ST_FULL;
                end
                if (s_tdata[1:0] == OP_QUERY && count_reg == '0) begin
                    status_reg <= ST_EMPTY;
                end
            end
            S_CHK0: idx_reg <= (q_reg <= rd_t) ? '0 : last_idx;
            S_CHKL: idx_reg <= (q_reg < rd_t) ? CW'(1) : last_idx;
            S_SCAN: begin
                tn_reg <= rd_t;
                xn_reg <= rd_x;
                yn_reg <= rd_y;
                zn_reg <= rd_z;
                if (!(q_reg <= rd_t)) begin
                    idx_reg <= idx_reg + CW'(1);
                end
            end
            S_RDP: begin
                tp_reg    <= rd_t;
                x_in_reg  <= rd_x;
                y_in_reg  <= rd_y;
                z_in_reg  <= rd_z;
                dstep_reg <= '0;
                axis_reg  <= '0;
            end
            S_DIV: begin
                if (dstep_reg == 5'd0) begin
                    gap_reg <= (tn_reg > tp_reg) ? {1'b0, tn_reg - tp_reg} : 33'd1;
                    // quotient register doubles as numerator shifter
                    quo_reg <= {numer[0], 16'd0};
                    x_in_reg <= x_in_reg;
                    rem_reg <= {18'd0, numer[31:1]};
                end else begin
                    if (!rem_sub[49]) begin
                        rem_reg <= rem_sub[48:0];
                        quo_reg <= {quo_reg[15:0], 1'b1};
                    end else begin
                        rem_reg <= rem_sh[48:0];
                        quo_reg <= {quo_reg[15:0], 1'b0};
                    end
                end
                dstep_reg <= dstep_reg + 5'd1;
                pa_reg    <= x_in_reg;
                pb_reg    <= xn_reg;
            end
            S_MUL: prod_reg <= diff * $signed({1'b0, alpha});
            S_MULW: begin
                case (axis_reg)
                    2'd0: begin
                        res_x_reg <= 32'(pa_reg + step[31:0]);
                        pa_reg <= y_in_reg;
                        pb_reg <= yn_reg;
                    end
                    2'd1: begin
                        res_y_reg <= 32'(pa_reg + step[31:0]);
                        pa_reg <= z_in_reg;
                        pb_reg <= zn_reg;
                    end
                    default: res_z_reg <= 32'(pa_reg + step[31:0]);
                endcase
                axis_reg <= axis_reg + 2'd1;
            end
            S_PICK: begin
                res_x_reg <= rd_x;
                res_y_reg <= rd_y;
                res_z_reg <= rd_z;
            end
            default: ;
        endcase
    end

    // Assertions.
    a_one_side: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid)) else $error("ready while result pending");
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(TABLE_DEPTH)) else $error("fill count overflow");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed under stall");
    a_base: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg != '0 |-> base_known_reg) else $error("samples without base");

endmodule

@@ bench/piecewise_linear_track_interp_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// piecewise_linear_track_interp_unit_tb: self-checking bench of the track unit
// Drives clear, append, query and unused-opcode requests through a table of
// directed rows, a fill to overflow and then random tracks, and predicts every
// result with an independent model of the sample table and its Q1.16 interpolation.
// ----------------------------------------------------------------------------
module piecewise_linear_track_interp_unit_tb;
    import pltip_pkg::*;

    localparam int DEPTH = 256;

    typedef struct packed {
        logic [31:0] pz;
        logic [31:0] py;
        logic [31:0] px;
        logic [31:0] t;
        opcode_t     op;
    } request_t;

    typedef struct packed {
        status_t     st;
        logic [31:0] z;
        logic [31:0] y;
        logic [31:0] x;
    } position_t;

    // One directed row: the request, and a fixed answer where it is obvious.
    typedef struct {
        request_t  req;
        bit        fixed;
        position_t ans;
    } row_t;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [135:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [103:0] m_tdata;

    piecewise_linear_track_interp_unit dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    // Private copy of the track table.
    logic [31:0] trk_t [DEPTH];
    logic [31:0] trk_x [DEPTH];
    logic [31:0] trk_y [DEPTH];
    logic [31:0] trk_z [DEPTH];
    int          trk_count;
    logic [31:0] trk_base;
    bit          trk_base_known;

    position_t   pending_positions[$];
    int          errors;
    bit          hold_receiver;
    row_t        rows[$];

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #200ms;
        $display("[piecewise_linear_track_interp_unit] ERROR");
        $finish;
    end

    // Q1.16 weighted blend of two samples, rounded toward minus infinity.
    function automatic logic [31:0] blend(logic [31:0] a, logic [31:0] b, int unsigned w);
        longint sa;
        longint prod;
        sa   = longint'($signed(a));
        prod = (longint'($signed(b)) - sa) * longint'(w);
        return 32'(sa + (prod >>> 16));
    endfunction

    // Applies one request to the private table and returns the expected result.
    function automatic position_t track_apply(request_t r);
        position_t   p;
        int          last;
        int          pick;
        bit          mid;
        logic [63:0] num;
        logic [63:0] gap;
        logic [63:0] w;
        p = '0;
        p.st = ST_OK;
        case (r.op)
            OP_CLEAR: begin
                trk_count = 0;
                trk_base_known = 0;
                trk_base = '0;
            end
            OP_APPEND: begin
                if (trk_count >= DEPTH) begin
                    p.st = ST_FULL;
                end else begin
                    if (!trk_base_known) begin
                        trk_base = r.t;
                        trk_base_known = 1;
                    end
                    trk_t[trk_count] = (r.t >= trk_base) ? r.t - trk_base : '0;
                    trk_x[trk_count] = r.px;
                    trk_y[trk_count] = r.py;
                    trk_z[trk_count] = r.pz;
                    trk_count++;
                end
            end
            OP_QUERY: begin
                if (trk_count == 0) begin
                    p.st = ST_EMPTY;
                end else begin
                    last = trk_count - 1;
                    pick = last;
                    mid = 0;
                    if (r.t <= trk_t[0]) begin
                        pick = 0;
                    end else if (r.t < trk_t[last]) begin
                        for (int i = 1; i < trk_count; i++) begin
                            if (r.t <= trk_t[i]) begin
                                pick = i;
                                mid = 1;
                                break;
                            end
                        end
                    end
                    if (mid) begin
                        num = (r.t > trk_t[pick-1]) ? 64'(r.t - trk_t[pick-1]) : 64'd0;
                        gap = (trk_t[pick] > trk_t[pick-1]) ?
                              64'(trk_t[pick] - trk_t[pick-1]) : 64'd1;
                        w = (num << 16) / gap;
                        if (w > 64'd65536) w = 64'd65536;
                        p.x = blend(trk_x[pick-1], trk_x[pick], int'(w));
                        p.y = blend(trk_y[pick-1], trk_y[pick], int'(w));
                        p.z = blend(trk_z[pick-1], trk_z[pick], int'(w));
                    end else begin
                        p.x = trk_x[pick];
                        p.y = trk_y[pick];
                        p.z = trk_z[pick];
                    end
                end
            end
            default: ;
        endcase
        return p;
    endfunction

    // Sends one request after a random gap; the prediction is queued at acceptance.
    // Valid stays high into the next request when that one follows with no gap.
    task automatic send_request(request_t r, bit fixed, position_t ans);
        position_t p;
        int        gap;
        gap = $urandom_range(0, 10);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tdata  <= {6'd0, r};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        p = track_apply(r);
        if (fixed && p !== ans) begin
            $display("%0t table row disagrees: expected %h, predicted %h", $time, ans, p);
            errors++;
        end
        pending_positions.push_back(p);
        @(negedge aclk);
    endtask

    function automatic request_t rand_request(opcode_t op, logic [31:0] t);
        request_t r;
        r.op = op;
        r.t  = t;
        r.px = $urandom;
        r.py = $urandom;
        r.pz = $urandom;
        // Mostly small moves, so the blend is easy to follow, some full range.
        if ($urandom_range(0, 3) != 0) begin
            r.px = 32'($signed(r.px[15:0]));
            r.py = 32'($signed(r.py[15:0]));
            r.pz = 32'($signed(r.pz[15:0]));
        end
        return r;
    endfunction

    function automatic request_t mk(opcode_t op, logic [31:0] t, logic [31:0] x,
                                    logic [31:0] y, logic [31:0] z);
        request_t r;
        r.op = op; r.t = t; r.px = x; r.py = y; r.pz = z;
        return r;
    endfunction

    function automatic position_t pos(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                      status_t st);
        position_t p;
        p.x = x; p.y = y; p.z = z; p.st = st;
        return p;
    endfunction

    function automatic row_t row(request_t r, bit fixed, position_t ans);
        row_t w;
        w.req = r; w.fixed = fixed; w.ans = ans;
        return w;
    endfunction

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_positions.size() != 0) @(negedge aclk);
    endtask

    // Receiver: random stall per result, plus one long hold-off on request.
    initial begin
        int n;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_receiver) begin
                m_tready <= 1'b0;
                repeat (3000) @(negedge aclk);
                hold_receiver = 0;
            end
            n = $urandom_range(0, 10);
            if (n != 0) begin
                m_tready <= 1'b0;
                repeat (n) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    // Result checker: compares every accepted result with the oldest prediction.
    always @(posedge aclk) begin
        position_t got;
        position_t exp_p;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[97:0];
            if (pending_positions.size() == 0) begin
                $display("%0t unexpected result %h", $time, got);
                errors++;
            end else begin
                exp_p = pending_positions.pop_front();
                if (got.x !== exp_p.x)
                    $display("%0t out_x expected %h actual %h", $time, exp_p.x, got.x);
                if (got.y !== exp_p.y)
                    $display("%0t out_y expected %h actual %h", $time, exp_p.y, got.y);
                if (got.z !== exp_p.z)
                    $display("%0t out_z expected %h actual %h", $time, exp_p.z, got.z);
                if (got.st !== exp_p.st)
                    $display("%0t status expected %0d actual %0d", $time, exp_p.st, got.st);
                if (got !== exp_p) errors++;
            end
        end
    end

    initial begin
        request_t    r;
        logic [31:0] tnow;
        int          n;
        int          sent;
        errors = 0;
        hold_receiver = 0;
        trk_count = 0;
        trk_base = '0;
        trk_base_known = 0;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        repeat (5) @(negedge aclk);
        aresetn = 1'b1;

        // Directed rows: empty queries, unused opcode, single sample, extremes,
        // a base time above later samples (floored to zero) and interpolation.
        rows.push_back(row(mk(OP_QUERY, 32'hFFFF_FFFF, '1, '1, '1), 1, pos(0, 0, 0, ST_EMPTY)));
        rows.push_back(row(mk(OP_NONE, 32'hFFFF_FFFF, '1, '1, '1), 1, pos(0, 0, 0, ST_OK)));
        rows.push_back(row(mk(OP_CLEAR, 0, '1, '1, '1), 1, pos(0, 0, 0, ST_OK)));
        rows.push_back(row(mk(OP_APPEND, 32'd1000, 32'h7FFF_FFFF, 32'h8000_0000, 32'd0),
                           1, pos(0, 0, 0, ST_OK)));
        rows.push_back(row(mk(OP_QUERY, 0, 0, 0, 0), 1,
                           pos(32'h7FFF_FFFF, 32'h8000_0000, 0, ST_OK)));
        rows.push_back(row(mk(OP_QUERY, 32'hFFFF_FFFF, 0, 0, 0), 1,
                           pos(32'h7FFF_FFFF, 32'h8000_0000, 0, ST_OK)));
        rows.push_back(row(mk(OP_APPEND, 32'd1100, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF),
                           1, pos(0, 0, 0, ST_OK)));
        rows.push_back(row(mk(OP_QUERY, 32'd50, 0, 0, 0), 0, '0));
        rows.push_back(row(mk(OP_QUERY, 32'd1, 0, 0, 0), 0, '0));
        rows.push_back(row(mk(OP_QUERY, 32'd99, 0, 0, 0), 0, '0));
        rows.push_back(row(mk(OP_QUERY, 32'd100, 0, 0, 0), 1,
                           pos(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, ST_OK)));
        rows.push_back(row(mk(OP_APPEND, 32'd10, 32'd256, 32'd512, 32'd768),
                           1, pos(0, 0, 0, ST_OK)));
        rows.push_back(row(mk(OP_QUERY, 32'd70, 0, 0, 0), 0, '0));
        rows.push_back(row(mk(OP_QUERY, 32'd200, 0, 0, 0), 1, pos(256, 512, 768, ST_OK)));
        rows.push_back(row(mk(OP_APPEND, 32'd1100, 32'd5, 32'd6, 32'd7), 1, pos(0, 0, 0, ST_OK)));
        rows.push_back(row(mk(OP_QUERY, 32'd40, 0, 0, 0), 0, '0));
        rows.push_back(row(mk(OP_CLEAR, 0, 0, 0, 0), 1, pos(0, 0, 0, ST_OK)));
        rows.push_back(row(mk(OP_QUERY, 32'd5, 0, 0, 0), 1, pos(0, 0, 0, ST_EMPTY)));
        foreach (rows[i]) send_request(rows[i].req, rows[i].fixed, rows[i].ans);

        // Fill the table to the brim, then overflow it.
        send_request(mk(OP_CLEAR, 0, 0, 0, 0), 0, '0);
        tnow = $urandom;
        for (int i = 0; i < DEPTH + 3; i++) begin
            if (i == 20) hold_receiver = 1;
            send_request(rand_request(OP_APPEND, tnow), 0, '0);
            tnow += $urandom_range(0, 400);
        end
        for (int i = 0; i < 6; i++)
            send_request(rand_request(OP_QUERY, tnow - $urandom_range(0, tnow - 32'd1)), 0, '0);
        send_request(rand_request(OP_QUERY, 32'hFFFF_FFFF), 0, '0);
        wait_drained();

        // Random tracks: small tables, mostly monotonic, sometimes scrambled.
        sent = 0;
        while (sent < 560) begin
            send_request(mk(OP_CLEAR, $urandom, $urandom, $urandom, $urandom), 0, '0);
            sent++;
            n = $urandom_range(1, 12);
            tnow = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 5000);
            for (int k = 0; k < n; k++) begin
                send_request(rand_request(OP_APPEND, tnow), 0, '0);
                sent++;
                if ($urandom_range(0, 7) == 0) tnow = $urandom;
                else tnow += $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 300);
            end
            for (int k = 0; k < $urandom_range(2, 8); k++) begin
                r = rand_request(OP_QUERY, $urandom_range(0, 3) == 0 ?
                                 $urandom : $urandom_range(0, 4000));
                if ($urandom_range(0, 15) == 0) r.op = opcode_t'($urandom_range(0, 3));
                send_request(r, 0, '0);
                sent++;
            end
        end

        wait_drained();
        repeat (200) @(negedge aclk);
        if (errors == 0 && pending_positions.size() == 0) begin
            $display("[piecewise_linear_track_interp_unit] OK");
        end else begin
            $display("[piecewise_linear_track_interp_unit] ERROR");
        end
        $finish;
    end

endmodule
